// ----- rtl/dit4_pkg.sv -----
// Package with the shared types, constants and arithmetic functions of the 4x4 dequant/transform.
`timescale 1ns / 1ps

package dit4_pkg;

    // Block geometry and fixed arithmetic constants.
    localparam int unsigned BLOCK_SIZE      = 16;
    localparam int unsigned ROUND_OFFSET    = 32;
    localparam int unsigned ROUND_SHIFT     = 6;
    localparam int unsigned DEQ_SHIFT_BASE  = 4;
    localparam int unsigned DEQ_ROUND_BASE  = 3;

    // Configuration register map.
    localparam int unsigned  CFG_ADDR_W          = 3;
    localparam int unsigned  CFG_DATA_W          = 32;
    localparam logic [CFG_ADDR_W-1:0] ADDR_RESIDUAL_LIMIT = 3'd0;
    localparam logic [8:0]   RESIDUAL_LIMIT_RESET = 9'd255;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_SCALE,
        ST_MUL_WEIGHT,
        ST_STORE,
        ST_LOAD,
        ST_CALC,
        ST_DC,
        ST_EMIT
    } state_t;

    // Transform pass.
    typedef enum logic {
        PASS_ROW,
        PASS_COL
    } pass_t;

    // One operand of the butterfly: 16 bits plus one for the halved tap.
    typedef logic [16:0] lane_t;

    // One output of the 4-point integer inverse butterfly, wrapping to 16 bits.
    // Bits [16:1] of a lane give the low 16 bits of the arithmetic half.
    function automatic logic [15:0] butterfly(input lane_t v0, input lane_t v1,
                                              input lane_t v2, input lane_t v3,
                                              input logic [1:0] sel);
        logic [15:0] x0;
        logic [15:0] x1;
        logic [15:0] x2;
        logic [15:0] x3;
        logic [15:0] y;
        x0 = v0[15:0] + v2[15:0];
        x1 = v0[15:0] - v2[15:0];
        x2 = v1[16:1] - v3[15:0];
        x3 = v1[15:0] + v3[16:1];
        case (sel)
            2'd0: begin
                y = x0 + x3;
            end
            2'd1: begin
                y = x1 + x2;
            end
            2'd2: begin
                y = x1 - x2;
            end
            default: begin
                y = x0 - x3;
            end
        endcase
        return y;
    endfunction

    // Symmetric clip of a rounded residual to [-lim, lim].
    function automatic logic [9:0] clip_residual(input logic signed [25:0] v,
                                                 input logic [8:0] lim);
        logic signed [25:0] lim_s;
        logic [9:0]         r;
        lim_s = $signed({17'd0, lim});
        if (v > lim_s) begin
            r = {1'b0, lim};
        end else if (v < -lim_s) begin
            r = 10'd0 - {1'b0, lim};
        end else begin
            r = v[9:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/dequant_inverse_transform_4x4.sv -----
// Top level: 4x4 dequantization and integer inverse transform with a small sequencer.
//
//   Channel   Direction  Handshake          Payload
//   s_*       in         s_valid/s_ready    coefficient, scale, weight, qp_div6,
//                                           dc_supplied, dc_only, dc_value
//   m_*       out        m_valid/m_ready    residual, last
//   APB       in         psel/penable       residual_limit at byte address 0
//
// Each coefficient item goes through accept, two passes through the shared
// multiplier (times scale, then times weight), and the rounding store.
// The sixteenth item starts the transform: 2 passes (row, then column) of 4 lines,
// each line 4 loads and 4 butterfly steps, or the DC step alone in DC-only mode,
// then 16 residuals leave through the output register, one per cycle when not stalled.
// s_ready is high only while the sequencer is idle; a stalled m_ready holds the emit.
// Reset (aresetn low, synchronous) clears the sequencer, position and modes and sets the limit to 255.
`timescale 1ns / 1ps

module dequant_inverse_transform_4x4 (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Coefficient input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [15:0]                 s_coefficient,
    input  logic [15:0]                        s_scale,
    input  logic [15:0]                        s_weight,
    input  logic [3:0]                         s_qp_div6,
    input  logic                               s_dc_supplied,
    input  logic                               s_dc_only,
    input  logic signed [15:0]                 s_dc_value,
    // Residual output channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [9:0]                  m_residual,
    output logic                               m_last,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dit4_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [dit4_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [dit4_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);

    // Sequencer and control registers
    dit4_pkg::state_t state_reg, state_next;
    dit4_pkg::pass_t  pass_reg, pass_next;
    logic [3:0]  pos_reg, pos_next;
    logic [1:0]  modes_reg, modes_next;
    logic [1:0]  line_reg, line_next;
    logic [1:0]  step_reg, step_next;
    logic [3:0]  out_idx_reg, out_idx_next;
    logic [8:0]  limit_reg;
    logic        m_valid_reg, m_valid_next;

    // Payload registers
    logic [15:0] coef_reg;
    logic [15:0] scale_reg;
    logic [15:0] weight_reg;
    logic [3:0]  q_reg;
    logic [15:0] dcval_reg;
    logic [9:0]  dc_res_reg, dc_res_next;
    logic [9:0]  m_residual_reg, m_residual_next;
    logic        m_last_reg, m_last_next;

    // Stores
    logic [31:0]           coeff_store_reg [dit4_pkg::BLOCK_SIZE];
    logic [15:0]           row_store_reg   [dit4_pkg::BLOCK_SIZE];
    dit4_pkg::lane_t       vec_reg         [4];

    // Store write and read controls
    logic        coeff_we;
    logic [3:0]  coeff_wr_idx;
    logic [31:0] coeff_wr_data;
    logic        row_we;
    logic [3:0]  row_wr_idx;
    logic        vec_we;
    logic [3:0]  coeff_rd_idx;
    logic [31:0] coeff_rd;
    logic [15:0] row_rd;
    dit4_pkg::lane_t load_data;

    // Arithmetic
    logic        mul_en;
    logic [31:0] mul_a;
    logic [15:0] mul_b;
    logic [31:0] mul_p;
    logic [31:0] deq_round;
    logic [31:0] deq_value;
    logic [15:0] bfly;
    logic [16:0] col_sum;
    logic [9:0]  col_res;
    logic [31:0] dc_sum;

    logic s_accept;
    logic cfg_write;

    assign s_ready  = (state_reg == dit4_pkg::ST_IDLE);
    assign s_accept = s_valid && s_ready;

    // Configuration port: always ready, one register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == dit4_pkg::ADDR_RESIDUAL_LIMIT[2]);
    assign prdata    = (paddr[2] == dit4_pkg::ADDR_RESIDUAL_LIMIT[2]) ?
                       {23'd0, limit_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= dit4_pkg::RESIDUAL_LIMIT_RESET;
        end else if (cfg_write) begin
            limit_reg <= pwdata[8:0];
        end
    end

    // Shared multiplier
    dit4_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    // Store read ports: one address each.
    always_comb begin
        case (state_reg)
            dit4_pkg::ST_LOAD: begin
                coeff_rd_idx = {line_reg, step_reg};
            end
            dit4_pkg::ST_DC: begin
                coeff_rd_idx = 4'd0;
            end
            default: begin
                coeff_rd_idx = out_idx_reg;
            end
        endcase
    end
    assign coeff_rd  = coeff_store_reg[coeff_rd_idx];
    assign row_rd    = row_store_reg[{step_reg, line_reg}];
    assign load_data = (pass_reg == dit4_pkg::PASS_ROW) ? coeff_rd[16:0]
                                                        : {row_rd[15], row_rd};

    // Dequantization rounding and shift of the registered product.
    always_comb begin
        deq_round = mul_p + (32'd1 << (2'd3 - q_reg[1:0]));
        if (q_reg < 4'(dit4_pkg::DEQ_SHIFT_BASE)) begin
            deq_value = 32'($signed(deq_round) >>> (3'd4 - {1'b0, q_reg[1:0]}));
        end else begin
            deq_value = mul_p << (q_reg - 4'(dit4_pkg::DEQ_SHIFT_BASE));
        end
    end

    // Butterfly step for both passes, and residual rounding for the column pass and DC-only mode.
    assign bfly    = dit4_pkg::butterfly(vec_reg[0], vec_reg[1], vec_reg[2], vec_reg[3],
                                         step_reg);
    assign col_sum = {bfly[15], bfly} + 17'(dit4_pkg::ROUND_OFFSET);
    assign col_res = dit4_pkg::clip_residual($signed({{15{col_sum[16]}}, col_sum[16:6]}),
                                             limit_reg);
    assign dc_sum  = coeff_rd + 32'(dit4_pkg::ROUND_OFFSET);

    // Sequencer: next state and datapath controls.
    always_comb begin
        state_next      = state_reg;
        pass_next       = pass_reg;
        pos_next        = pos_reg;
        modes_next      = modes_reg;
        line_next       = line_reg;
        step_next       = step_reg;
        out_idx_next    = out_idx_reg;
        dc_res_next     = dc_res_reg;
        m_valid_next    = m_valid_reg;
        m_residual_next = m_residual_reg;
        m_last_next     = m_last_reg;
        coeff_we        = 1'b0;
        coeff_wr_idx    = pos_reg;
        coeff_wr_data   = deq_value;
        row_we          = 1'b0;
        row_wr_idx      = {line_reg, step_reg};
        vec_we          = 1'b0;
        mul_en          = 1'b0;
        mul_a           = {{16{coef_reg[15]}}, coef_reg};
        mul_b           = scale_reg;

        // The output register empties when its item is taken.
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            dit4_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (pos_reg == 4'd0) begin
                        modes_next = {s_dc_only, s_dc_supplied};
                    end
                    state_next = dit4_pkg::ST_MUL_SCALE;
                end
            end
            dit4_pkg::ST_MUL_SCALE: begin
                mul_en     = 1'b1;
                state_next = dit4_pkg::ST_MUL_WEIGHT;
            end
            dit4_pkg::ST_MUL_WEIGHT: begin
                mul_en     = 1'b1;
                mul_a      = mul_p;
                mul_b      = weight_reg;
                state_next = dit4_pkg::ST_STORE;
            end
            dit4_pkg::ST_STORE: begin
                coeff_we = 1'b1;
                if (pos_reg == 4'd0 && modes_reg[0]) begin
                    coeff_wr_data = {{16{dcval_reg[15]}}, dcval_reg};
                end
                pos_next = pos_reg + 4'd1;
                if (pos_reg == 4'(dit4_pkg::BLOCK_SIZE - 1)) begin
                    if (modes_reg[1]) begin
                        state_next = dit4_pkg::ST_DC;
                    end else begin
                        pass_next  = dit4_pkg::PASS_ROW;
                        line_next  = 2'd0;
                        step_next  = 2'd0;
                        state_next = dit4_pkg::ST_LOAD;
                    end
                end else begin
                    state_next = dit4_pkg::ST_IDLE;
                end
            end
            dit4_pkg::ST_LOAD: begin
                vec_we    = 1'b1;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    state_next = dit4_pkg::ST_CALC;
                end
            end
            dit4_pkg::ST_CALC: begin
                if (pass_reg == dit4_pkg::PASS_ROW) begin
                    row_we = 1'b1;
                end else begin
                    // Column results overwrite the consumed coefficients, raster indexed.
                    coeff_we      = 1'b1;
                    coeff_wr_idx  = {step_reg, line_reg};
                    coeff_wr_data = {{22{col_res[9]}}, col_res};
                end
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    line_next = line_reg + 2'd1;
                    if (line_reg == 2'd3) begin
                        if (pass_reg == dit4_pkg::PASS_ROW) begin
                            pass_next  = dit4_pkg::PASS_COL;
                            state_next = dit4_pkg::ST_LOAD;
                        end else begin
                            out_idx_next = 4'd0;
                            state_next   = dit4_pkg::ST_EMIT;
                        end
                    end else begin
                        state_next = dit4_pkg::ST_LOAD;
                    end
                end
            end
            dit4_pkg::ST_DC: begin
                dc_res_next  = dit4_pkg::clip_residual($signed(dc_sum[31:6]), limit_reg);
                out_idx_next = 4'd0;
                state_next   = dit4_pkg::ST_EMIT;
            end
            dit4_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_residual_next = modes_reg[1] ? dc_res_reg : coeff_rd[9:0];
                    m_last_next     = (out_idx_reg == 4'(dit4_pkg::BLOCK_SIZE - 1));
                    out_idx_next    = out_idx_reg + 4'd1;
                    if (out_idx_reg == 4'(dit4_pkg::BLOCK_SIZE - 1)) begin
                        state_next = dit4_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = dit4_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dit4_pkg::ST_IDLE;
            pass_reg    <= dit4_pkg::PASS_ROW;
            pos_reg     <= 4'd0;
            modes_reg   <= 2'd0;
            line_reg    <= 2'd0;
            step_reg    <= 2'd0;
            out_idx_reg <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pass_reg    <= pass_next;
            pos_reg     <= pos_next;
            modes_reg   <= modes_next;
            line_reg    <= line_next;
            step_reg    <= step_next;
            out_idx_reg <= out_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers: input item capture and output register.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            coef_reg   <= s_coefficient;
            scale_reg  <= s_scale;
            weight_reg <= s_weight;
            q_reg      <= s_qp_div6;
            dcval_reg  <= s_dc_value;
        end
        dc_res_reg     <= dc_res_next;
        m_residual_reg <= m_residual_next;
        m_last_reg     <= m_last_next;
    end

    // Stores: one write each per cycle.
    always_ff @(posedge aclk) begin
        if (coeff_we) begin
            coeff_store_reg[coeff_wr_idx] <= coeff_wr_data;
        end
        if (row_we) begin
            row_store_reg[row_wr_idx] <= bfly;
        end
        if (vec_we) begin
            vec_reg[step_reg] <= load_data;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_residual = $signed(m_residual_reg);
    assign m_last     = m_last_reg;

endmodule

// ----- rtl/dit4_mul.sv -----
// Shared 32x16 multiplier with a registered product, wrapping to 32 bits.
`timescale 1ns / 1ps

module dit4_mul (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [15:0] b,
    output logic [31:0] p
);

    logic [47:0] full;
    logic [31:0] p_reg;

    // Only the low 32 bits are kept; two's complement makes this signed-correct.
    assign full = a * b;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= full[31:0];
        end
    end

    assign p = p_reg;

endmodule

// ----- rtl/dit4_checker.sv -----
// Port-level checker for the 4x4 dequant/transform, bound to the top level.
`timescale 1ns / 1ps

module dit4_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic signed [9:0] m_residual,
    input logic              m_last,
    input logic              pready
);

    // A waiting result item keeps its payload until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_residual) && $stable(m_last))
        else $error("result item changed while stalled");

    // While a block is still being emitted, no new input item is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input ready in the middle of a block");

    // The clip bound never exceeds 511, so -512 cannot appear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_residual != 10'sh200)
        else $error("residual outside the clip range");

    // The configuration port never inserts wait states.
    assert property (@(posedge aclk)
        pready == 1'b1)
        else $error("configuration port not ready");

endmodule

bind dequant_inverse_transform_4x4 dit4_checker u_dit4_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_residual (m_residual),
    .m_last     (m_last),
    .pready     (pready)
);

// ----- tb/sv/dequant_inverse_transform_4x4_checker.sv -----
// Checker that predicts the residuals of the 4x4 dequant/transform and compares them on the output.
`timescale 1ns / 1ps

module dequant_inverse_transform_4x4_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic signed [15:0]                 s_coefficient,
    input  logic [15:0]                        s_scale,
    input  logic [15:0]                        s_weight,
    input  logic [3:0]                         s_qp_div6,
    input  logic                               s_dc_supplied,
    input  logic                               s_dc_only,
    input  logic signed [15:0]                 s_dc_value,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic signed [9:0]                  m_residual,
    input  logic                               m_last,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dit4_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [dit4_pkg::CFG_DATA_W-1:0]    pwdata,
    input  logic                               pready,
    output int                                 error_count,
    output int                                 pending_count
);

    // One expected residual item.
    typedef struct packed {
        logic signed [9:0] residual;
        logic              last;
    } residual_expect_t;

    residual_expect_t   residual_q[$];
    logic [8:0]         clip_limit;
    logic signed [31:0] dequant_store [16];
    logic [3:0]         coeff_pos;
    logic               keep_dc;
    logic               flat_block;
    residual_expect_t   want;

    // Dequantization with 32-bit wrap of product, then a rounding add and right shift, or a left shift.
    function automatic logic signed [31:0] dequantize(input logic signed [15:0] c,
                                                      input logic [15:0] s,
                                                      input logic [15:0] w,
                                                      input logic [3:0] q);
        logic [31:0] p;
        p = 32'(c) * 32'(s) * 32'(w);
        if (q < dit4_pkg::DEQ_SHIFT_BASE) begin
            p = p + (32'd1 << (dit4_pkg::DEQ_ROUND_BASE - q));
            return $signed(p) >>> (dit4_pkg::DEQ_SHIFT_BASE - q);
        end
        return $signed(p << (q - dit4_pkg::DEQ_SHIFT_BASE));
    endfunction

    // Symmetric clip against the current limit.
    function automatic logic signed [9:0] clip_to_limit(input logic signed [31:0] v);
        logic signed [31:0] bound;
        bound = $signed({23'd0, clip_limit});
        if (v > bound) begin
            return 10'(bound);
        end
        if (v < -bound) begin
            return 10'(-bound);
        end
        return 10'(v);
    endfunction

    // One 4-point inverse butterfly; every sum wraps to 16 bits.
    task automatic inverse_butterfly(input logic signed [31:0] e0, input logic signed [31:0] e1,
                                     input logic signed [31:0] e2, input logic signed [31:0] e3,
                                     output logic [3:0][15:0] y);
        logic [15:0] x0;
        logic [15:0] x1;
        logic [15:0] x2;
        logic [15:0] x3;
        x0 = 16'(e0 + e2);
        x1 = 16'(e0 - e2);
        x2 = 16'((e1 >>> 1) - e3);
        x3 = 16'(e1 + (e3 >>> 1));
        y[0] = x0 + x3;
        y[1] = x1 + x2;
        y[2] = x1 - x2;
        y[3] = x0 - x3;
    endtask

    // Build the 16 residuals of a completed block and queue them in raster order.
    task automatic predict_block();
        logic [3:0][15:0]   lanes;
        logic [15:0]        row_out [16];
        logic signed [31:0] rounded;
        logic signed [9:0]  residual_out [16];
        residual_expect_t   item;
        if (flat_block) begin
            rounded = dequant_store[0] + dit4_pkg::ROUND_OFFSET;
            rounded = rounded >>> dit4_pkg::ROUND_SHIFT;
            for (int k = 0; k < 16; k++) begin
                residual_out[k] = clip_to_limit(rounded);
            end
        end else begin
            for (int r = 0; r < 4; r++) begin
                inverse_butterfly(dequant_store[4*r], dequant_store[4*r+1],
                                  dequant_store[4*r+2], dequant_store[4*r+3], lanes);
                for (int c = 0; c < 4; c++) begin
                    row_out[4*r+c] = lanes[c];
                end
            end
            for (int c = 0; c < 4; c++) begin
                inverse_butterfly(32'($signed(row_out[c])), 32'($signed(row_out[4+c])),
                                  32'($signed(row_out[8+c])), 32'($signed(row_out[12+c])),
                                  lanes);
                for (int r = 0; r < 4; r++) begin
                    rounded = 32'($signed(lanes[r])) + dit4_pkg::ROUND_OFFSET;
                    rounded = rounded >>> dit4_pkg::ROUND_SHIFT;
                    residual_out[4*r+c] = clip_to_limit(rounded);
                end
            end
        end
        for (int k = 0; k < 16; k++) begin
            item.residual = residual_out[k];
            item.last = (k == dit4_pkg::BLOCK_SIZE - 1);
            residual_q.push_back(item);
        end
    endtask

    // Watch all three ports at the rising edge; outputs are compared before new items count.
    always @(posedge aclk) begin
        if (!aresetn) begin
            clip_limit = dit4_pkg::RESIDUAL_LIMIT_RESET;
            coeff_pos = 4'd0;
            keep_dc = 1'b0;
            flat_block = 1'b0;
        end else begin
            if (psel && penable && pwrite && pready &&
                paddr == dit4_pkg::ADDR_RESIDUAL_LIMIT) begin
                clip_limit = pwdata[8:0];
            end
            if (m_valid && m_ready) begin
                if (residual_q.size() == 0) begin
                    $error("unexpected residual item: residual %0d last %0b",
                           m_residual, m_last);
                    error_count++;
                end else begin
                    want = residual_q.pop_front();
                    if (m_residual !== want.residual) begin
                        $error("residual: expected %0d, actual %0d",
                               $signed(want.residual), m_residual);
                        error_count++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, m_last);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                // Mode bits only count on the first coefficient of a block.
                if (coeff_pos == 4'd0) begin
                    keep_dc = s_dc_supplied;
                    flat_block = s_dc_only;
                end
                if (coeff_pos == 4'd0 && keep_dc) begin
                    dequant_store[0] = 32'(s_dc_value);
                end else begin
                    dequant_store[coeff_pos] = dequantize(s_coefficient, s_scale, s_weight,
                                                          s_qp_div6);
                end
                if (coeff_pos == 4'(dit4_pkg::BLOCK_SIZE - 1)) begin
                    predict_block();
                end
                coeff_pos = coeff_pos + 4'd1;
            end
        end
        pending_count = residual_q.size();
    end

endmodule

// ----- tb/sv/dequant_inverse_transform_4x4_tb.sv -----
// Testbench top: clock, reset, stimulus, output pacing and verdict for the 4x4 dequant/transform.
`timescale 1ns / 1ps

module dequant_inverse_transform_4x4_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int CFG_SETTLE   = 16;

    typedef enum {BLOCK_TYPICAL, BLOCK_NOISE} block_style_t;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic signed [15:0]                  s_coefficient;
    logic [15:0]                         s_scale;
    logic [15:0]                         s_weight;
    logic [3:0]                          s_qp_div6;
    logic                                s_dc_supplied;
    logic                                s_dc_only;
    logic signed [15:0]                  s_dc_value;
    logic                                m_valid;
    logic                                m_ready;
    logic signed [9:0]                   m_residual;
    logic                                m_last;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [dit4_pkg::CFG_ADDR_W-1:0]     paddr;
    logic [dit4_pkg::CFG_DATA_W-1:0]     pwdata;
    logic [dit4_pkg::CFG_DATA_W-1:0]     prdata;
    logic                                pready;

    int error_count;
    int pending_count;
    int cycle_count = 0;
    bit idle_en = 1'b1;
    bit long_hold_req = 1'b0;

    dequant_inverse_transform_4x4 u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_coefficient (s_coefficient),
        .s_scale       (s_scale),
        .s_weight      (s_weight),
        .s_qp_div6     (s_qp_div6),
        .s_dc_supplied (s_dc_supplied),
        .s_dc_only     (s_dc_only),
        .s_dc_value    (s_dc_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_residual    (m_residual),
        .m_last        (m_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    dequant_inverse_transform_4x4_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_coefficient (s_coefficient),
        .s_scale       (s_scale),
        .s_weight      (s_weight),
        .s_qp_div6     (s_qp_div6),
        .s_dc_supplied (s_dc_supplied),
        .s_dc_only     (s_dc_only),
        .s_dc_value    (s_dc_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_residual    (m_residual),
        .m_last        (m_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // 100 MHz clock.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("run exceeded %0d cycles, %0d residuals still expected",
                   CYCLE_LIMIT, pending_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Output pacing: random stall bursts, one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Write the residual limit through a setup and an access cycle.
    task automatic write_residual_limit(input logic [8:0] value);
        @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = dit4_pkg::ADDR_RESIDUAL_LIMIT;
        pwdata = {23'($urandom), value};
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Stop offering items and wait until every predicted residual has come out.
    task automatic wait_residuals_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (CFG_SETTLE) @(negedge aclk);
    endtask

    // Offer one coefficient item, with an optional idle burst first.
    task automatic send_coefficient(input logic signed [15:0] coef, input logic [15:0] scale,
                                    input logic [15:0] weight, input logic [3:0] qp,
                                    input logic dc_supplied, input logic dc_only,
                                    input logic signed [15:0] dc_value);
        @(negedge aclk);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_coefficient = coef;
        s_scale = scale;
        s_weight = weight;
        s_qp_div6 = qp;
        s_dc_supplied = dc_supplied;
        s_dc_only = dc_only;
        s_dc_value = dc_value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // One whole block: modes at the first position, random mode bits afterwards.
    task automatic send_block(input block_style_t style, input logic [1:0] modes);
        logic signed [15:0] coef;
        logic [15:0]        scale;
        logic [15:0]        weight;
        logic [3:0]         qp;
        logic [3:0]         block_qp;
        logic [1:0]         mode_bits;
        logic signed [15:0] dc_value;
        block_qp = 4'($urandom_range(0, 8));
        for (int pos = 0; pos < 16; pos++) begin
            mode_bits = (pos == 0) ? modes : 2'($urandom);
            if (style == BLOCK_NOISE) begin
                coef = 16'($urandom);
                scale = 16'($urandom);
                weight = 16'($urandom);
                qp = 4'($urandom);
                dc_value = 16'($urandom);
            end else begin
                // Mostly zeros and small levels, as a real residual block holds.
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: coef = 16'sd0;
                    5, 6, 7, 8: coef = 16'($signed($urandom_range(0, 64)) - 32);
                    default: coef = 16'($signed($urandom_range(0, 4094)) - 2047);
                endcase
                scale = 16'($urandom_range(10, 25));
                weight = 16'($urandom_range(6, 64));
                qp = block_qp;
                dc_value = 16'($signed($urandom_range(0, 8192)) - 4096);
            end
            send_coefficient(coef, scale, weight, qp, mode_bits[0], mode_bits[1], dc_value);
        end
    endtask

    // Main stimulus.
    initial begin
        logic [8:0]   limit;
        block_style_t style;
        logic [1:0]   modes;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_coefficient = '0;
        s_scale = '0;
        s_weight = '0;
        s_qp_div6 = '0;
        s_dc_supplied = 1'b0;
        s_dc_only = 1'b0;
        s_dc_value = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Supplied DC replaces an extreme first coefficient; later mode bits are ignored.
        send_coefficient(16'sd32767, 16'hffff, 16'hffff, 4'd15, 1'b1, 1'b0, -16'sd32768);
        send_coefficient(-16'sd32768, 16'hffff, 16'hffff, 4'd15, 1'b1, 1'b1, 16'sd32767);
        send_coefficient(16'sd32767, 16'hffff, 16'hffff, 4'd0, 1'b0, 1'b0, 16'sd0);
        send_coefficient(16'sd1, 16'd1, 16'd1, 4'd3, 1'b0, 1'b0, 16'sd0);
        send_coefficient(-16'sd1, 16'd1, 16'd1, 4'd0, 1'b1, 1'b0, 16'sd0);
        send_coefficient(16'sd0, 16'd0, 16'd0, 4'd4, 1'b0, 1'b1, 16'sd0);
        send_coefficient(-16'sd1, 16'd1, 16'd1, 4'd4, 1'b0, 1'b0, 16'sd0);
        // Product 2^30-1 shifted left lands just under the 32-bit sign bit.
        send_coefficient(16'sd1, 16'd32767, 16'd32769, 4'd5, 1'b0, 1'b0, 16'sd0);
        for (int pos = 8; pos < 16; pos++) begin
            send_coefficient(16'((pos % 2 == 0) ? pos * 1000 : -pos * 1000),
                             16'(65535 - pos), 16'(pos), 4'(pos), 1'b0, 1'b0, 16'sd0);
        end

        // DC-only block whose DC wraps when the rounding offset is added.
        send_coefficient(16'sd1, 16'd32767, 16'd32769, 4'd5, 1'b0, 1'b1, 16'sd0);
        for (int pos = 1; pos < 16; pos++) begin
            send_coefficient(16'($urandom), 16'($urandom), 16'($urandom), 4'($urandom),
                             1'($urandom), 1'($urandom), 16'($urandom));
        end

        // Random phases, each under its own residual limit.
        for (int phase = 0; phase < 5; phase++) begin
            wait_residuals_drained();
            case (phase)
                0: limit = 9'd511;
                1: limit = 9'd0;
                3: limit = 9'd1;
                default: limit = 9'($urandom_range(2, 510));
            endcase
            write_residual_limit(limit);
            if (phase == 2) begin
                long_hold_req = 1'b1;
            end
            if (phase == 4) begin
                idle_en = 1'b0;
            end
            for (int blk = 0; blk < ((phase == 2) ? 2 : 1); blk++) begin
                style = ($urandom_range(0, 3) == 0) ? BLOCK_NOISE : BLOCK_TYPICAL;
                modes = $urandom_range(0, 1) ? 2'd0 : 2'($urandom_range(1, 3));
                if (phase == 0 && blk == 0) begin
                    style = BLOCK_TYPICAL;
                    modes = 2'b11;
                end
                send_block(style, modes);
            end
        end

        // Drain and give the verdict.
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_count == 0 && pending_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dit4_pkg.sv
rtl/dit4_mul.sv
rtl/dequant_inverse_transform_4x4.sv
rtl/dit4_checker.sv
tb/sv/dequant_inverse_transform_4x4_checker.sv
tb/sv/dequant_inverse_transform_4x4_tb.sv
